FILE: hw/rtl/mlp_sigmoid_train_infer_top_defines.svh
// Assertion helpers for the perceptron block.
// Each expects clk and rst_n in scope.
`ifndef MLP_SIGMOID_TRAIN_INFER_TOP_DEFINES_SVH
`define MLP_SIGMOID_TRAIN_INFER_TOP_DEFINES_SVH

// Same-cycle implication
`define MLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlp check failed");

// Next-cycle implication
`define MLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlp check failed");

`endif

FILE: hw/rtl/mlp_pkg.sv
`default_nettype none

package mlp_pkg;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_INFER = 2'd2;
  localparam logic [1:0] OP_TRAIN = 2'd3;

  // Training labels
  localparam logic [2:0] CLS_WHITE = 3'd3;
  localparam int         ONEHOT_CLASSES = 3;

  // One-hot targets, bit j is output j
  localparam logic [2:0] ONE_HOT [ONEHOT_CLASSES] = '{3'b001, 3'b010, 3'b100};

  localparam logic [12:0] LR_RESET = 13'd409;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         target_class;
    logic [7:0]         weight_index;
    logic signed [15:0] weight_value;
  } item_t;

  typedef struct packed {
    logic [12:0]        out_red;
    logic [12:0]        out_green;
    logic [12:0]        out_blue;
    logic signed [15:0] weight_read;
  } res_t;

  // Weight store request
  typedef struct packed {
    logic               we;
    logic               re;
    logic [7:0]         addr;
    logic signed [15:0] wdata;
  } mem_req_t;

  // Shared multiply-accumulate request
  typedef struct packed {
    logic               mul_en;
    logic               acc_en;
    logic               acc_load;
    logic signed [30:0] a;
    logic signed [16:0] b;
  } mac_req_t;

  typedef struct packed {
    logic signed [47:0] prod;
    logic signed [47:0] acc;
  } mac_out_t;

  // Round to nearest, ties up, drop 12 fraction bits
  function automatic logic signed [47:0] round12(input logic signed [47:0] v);
    round12 = (v + 48'sd2048) >>> 12;
  endfunction

  function automatic logic signed [47:0] round24(input logic signed [47:0] v);
    round24 = (v + 48'sd8388608) >>> 24;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -48'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // Sigmoid table entry for Q4.12 point t, evaluated at elaboration only.
  // exp via series up to the 12th power of |t|/16, then squared four times.
  function automatic logic [12:0] sig_value(input int t);
    longint unsigned U;
    longint unsigned TERM;
    longint unsigned S;
    longint unsigned D;
    longint unsigned R;
    longint unsigned MAG;
    longint unsigned N;
    MAG  = (t < 0) ? longint'(-t) : longint'(t);
    U    = MAG << 8;
    TERM = 64'd1 << 24;
    S    = TERM;
    for (N = 1; N <= 12; N++) begin
      TERM = ((TERM * U) >> 24) / N;
      S    = S + TERM;
    end
    for (N = 0; N < 4; N++) begin
      S = (S * S) >> 24;
    end
    D = (64'd1 << 24) + S;
    R = ((64'd1 << 36) + D / 2) / D;
    sig_value = (t < 0) ? 13'(R) : 13'(64'd4096 - R);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mlp_ifs.sv
`default_nettype none

// Request channel into the block
interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [2:0]         target_class;
  logic [7:0]         weight_index;
  logic signed [15:0] weight_value;
  modport source (output valid, op, x, y, target_class, weight_index, weight_value,
                  input ready);
  modport sink   (input valid, op, x, y, target_class, weight_index, weight_value,
                  output ready);
endinterface

// Result channel out of the block
interface mlp_out_if;
  logic               valid;
  logic               ready;
  logic [12:0]        out_red;
  logic [12:0]        out_green;
  logic [12:0]        out_blue;
  logic signed [15:0] weight_read;
  modport source (output valid, out_red, out_green, out_blue, weight_read, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, weight_read, output ready);
endinterface

// Learning rate write channel
interface mlp_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] step_size;
  modport source (output valid, step_size, input ready);
  modport sink   (input valid, step_size, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mlp_wmem.sv
`default_nettype none

// Single-port weight store, registered read
module mlp_wmem (
  input  wire logic                clk,
  input  wire mlp_pkg::mem_req_t   req,
  output logic signed [15:0]       rdata
);

  logic signed [15:0] mem [256];
  logic signed [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mlp_mac.sv
`default_nettype none

// Shared 31x17 signed multiplier with product register and accumulator
module mlp_mac (
  input  wire logic              clk,
  input  wire mlp_pkg::mac_req_t req,
  output mlp_pkg::mac_out_t      res
);

  logic signed [47:0] prod_r;
  logic signed [47:0] acc_r;

  always_ff @(posedge clk) begin
    if (req.mul_en) begin
      // operands sign-extended to the full product width
      prod_r <= 48'(req.a) * 48'(req.b);
    end
    // first term loads, later terms add
    if (req.acc_en) begin
      acc_r <= req.acc_load ? prod_r : acc_r + prod_r;
    end
  end

  assign res.prod = prod_r;
  assign res.acc  = acc_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mlp_ctrl.sv
`default_nettype none

// Sequencer: store clear, weight write and read, forward pass, deltas and weight update over the shared MAC
module mlp_ctrl #(
  parameter int HIDDEN_LAYERS       = 2,
  parameter int HIDDEN_WIDTH        = 8,
  parameter int OUTPUT_COUNT        = 3,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mlp_pkg::item_t     in_item,
  input  wire logic [12:0]        lr,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output mlp_pkg::res_t           res,
  output mlp_pkg::mem_req_t       mem_req,
  input  wire logic signed [15:0] mem_rdata,
  output mlp_pkg::mac_req_t       mac_req,
  input  wire mlp_pkg::mac_out_t  mac_out
);

  localparam int NT  = 2 + HIDDEN_LAYERS * HIDDEN_WIDTH + OUTPUT_COUNT;
  localparam int AW  = $clog2(NT);
  localparam int TW  = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int OB  = 2 + HIDDEN_LAYERS * HIDDEN_WIDTH;
  localparam int OB1 = (OUTPUT_COUNT > 1) ? OB + 1 : OB;
  localparam int OB2 = (OUTPUT_COUNT > 2) ? OB + 2 : OB;

  typedef enum logic [23:0] {
    ST_CLEAR = 24'h000001, ST_IDLE  = 24'h000002, ST_RDW   = 24'h000004,
    ST_F_RD  = 24'h000008, ST_F_MUL = 24'h000010, ST_F_ACC = 24'h000020,
    ST_F_SIG = 24'h000040, ST_F_WR  = 24'h000080, ST_RES   = 24'h000100,
    ST_O_D   = 24'h000200, ST_O_DR  = 24'h000400, ST_O_M   = 24'h000800,
    ST_O_W   = 24'h001000, ST_B_RD  = 24'h002000, ST_B_MUL = 24'h004000,
    ST_B_ACC = 24'h008000, ST_B_ERR = 24'h010000, ST_B_DR  = 24'h020000,
    ST_B_M   = 24'h040000, ST_B_W   = 24'h080000, ST_U_RD  = 24'h100000,
    ST_U_M2  = 24'h200000, ST_U_WR  = 24'h400000, ST_DONE  = 24'h800000
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         clr_r, clr_nxt;
  logic [1:0]         l_r, l_nxt;
  logic [2:0]         j_r, j_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [1:0]         op_r;
  logic [2:0]         cls_r;
  logic [10:0]        d_r;
  logic signed [15:0] err_r;
  logic [12:0]        sig_r;
  mlp_pkg::res_t      res_r;

  logic signed [15:0] act_r [NT];
  logic signed [15:0] dlt_r [NT];

  // Sigmoid table, constant
  logic [12:0] sig_tbl [SIGMOID_TABLE_DEPTH];
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_sig
    localparam int T = -32768 + (g * 65536) / SIGMOID_TABLE_DEPTH;
    assign sig_tbl[g] = mlp_pkg::sig_value(T);
  end

  // Neuron layer base index and last neuron within layer
  function automatic logic [AW-1:0] nbase(input logic [2:0] n);
    nbase = (n == 3'd0) ? '0 : AW'(2 + (int'(n) - 1) * HIDDEN_WIDTH);
  endfunction

  function automatic logic [2:0] nlast(input logic [2:0] n);
    if (n == 3'd0) begin
      nlast = 3'd1;
    end else if (n == 3'(HIDDEN_LAYERS + 1)) begin
      nlast = 3'(OUTPUT_COUNT - 1);
    end else begin
      nlast = 3'(HIDDEN_WIDTH - 1);
    end
  endfunction

  logic [2:0]         ln_src, ln_dst;
  logic [AW-1:0]      sb, db, act_idx, dlt_idx;
  logic [2:0]         src_last, dst_last;
  logic signed [15:0] act_rd, dlt_rd;
  logic signed [15:0] z;
  logic [15:0]        uz;
  logic [TW-1:0]      sig_idx;
  logic signed [30:0] tgt;
  logic               accept;

  assign ln_src   = {1'b0, l_r};
  assign ln_dst   = {1'b0, l_r} + 3'd1;
  assign sb       = nbase(ln_src);
  assign db       = nbase(ln_dst);
  assign src_last = nlast(ln_src);
  assign dst_last = nlast(ln_dst);

  // Store read ports, one address each
  always_comb begin
    if (state_r == ST_O_D || state_r == ST_O_M) begin
      act_idx = AW'(OB) + AW'(j_r);
    end else if (state_r == ST_B_ERR) begin
      act_idx = sb + AW'(j_r);
    end else begin
      act_idx = sb + AW'(k_r);
    end
    dlt_idx = (state_r == ST_U_RD) ? db + AW'(j_r) : db + AW'(k_r);
  end
  assign act_rd = act_r[act_idx];
  assign dlt_rd = dlt_r[dlt_idx];

  // Sigmoid lookup index from saturated neuron sum
  assign z       = mlp_pkg::sat16(mlp_pkg::round12(mac_out.acc));
  assign uz      = {~z[15], z[14:0]};
  assign sig_idx = TW'((32'(uz) * SIGMOID_TABLE_DEPTH) >> 16);

  // Output target
  always_comb begin
    if (cls_r < 3'(mlp_pkg::ONEHOT_CLASSES)) begin
      tgt = mlp_pkg::ONE_HOT[cls_r[1:0]][j_r[1:0]] ? 31'sd4096 : 31'sd0;
    end else if (cls_r == mlp_pkg::CLS_WHITE) begin
      tgt = 31'sd4096;
    end else begin
      tgt = 31'sd0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    l_nxt     = l_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mem_req   = '0;
    mac_req   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_r;
        clr_nxt      = clr_r + 8'd1;
        if (clr_r == 8'hFF) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_req.addr  = in_item.weight_index;
        mem_req.wdata = in_item.weight_value;
        if (accept) begin
          l_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          if (in_item.op == mlp_pkg::OP_WRITE) begin
            mem_req.we = 1'b1;
            state_nxt  = ST_DONE;
          end else if (in_item.op == mlp_pkg::OP_READ) begin
            mem_req.re = 1'b1;
            state_nxt  = ST_RDW;
          end else begin
            state_nxt = ST_F_RD;
          end
        end
      end
      ST_RDW: state_nxt = ST_DONE;
      // forward: one weight times one activation per pass
      ST_F_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = {l_r, k_r, j_r};
        state_nxt    = ST_F_MUL;
      end
      ST_F_MUL: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(act_rd);
        mac_req.b      = 17'(mem_rdata);
        state_nxt      = ST_F_ACC;
      end
      ST_F_ACC: begin
        mac_req.acc_en   = 1'b1;
        mac_req.acc_load = (k_r == 3'd0);
        if (k_r == src_last) begin
          state_nxt = ST_F_SIG;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = ST_F_RD;
        end
      end
      ST_F_SIG: state_nxt = ST_F_WR;
      ST_F_WR: begin
        k_nxt     = '0;
        state_nxt = ST_F_RD;
        if (j_r == dst_last) begin
          j_nxt = '0;
          if (l_r == 2'(HIDDEN_LAYERS)) begin
            state_nxt = ST_RES;
          end else begin
            l_nxt = l_r + 2'd1;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      ST_RES: begin
        j_nxt     = '0;
        state_nxt = (op_r == mlp_pkg::OP_TRAIN) ? ST_O_D : ST_DONE;
      end
      // output deltas
      ST_O_D: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(act_rd);
        mac_req.b      = 17'sd4096 - 17'(act_rd);
        state_nxt      = ST_O_DR;
      end
      ST_O_DR: state_nxt = ST_O_M;
      ST_O_M: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(act_rd) - tgt;
        mac_req.b      = {6'b0, d_r};
        state_nxt      = ST_O_W;
      end
      ST_O_W: begin
        if (j_r == 3'(OUTPUT_COUNT - 1)) begin
          j_nxt     = '0;
          k_nxt     = '0;
          l_nxt     = 2'(HIDDEN_LAYERS);
          state_nxt = ST_B_RD;
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = ST_O_D;
        end
      end
      // hidden deltas, last hidden layer first
      ST_B_RD: begin
        mem_req.re   = 1'b1;
        mem_req.addr = {l_r, j_r, k_r};
        state_nxt    = ST_B_MUL;
      end
      ST_B_MUL: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(dlt_rd);
        mac_req.b      = 17'(mem_rdata);
        state_nxt      = ST_B_ACC;
      end
      ST_B_ACC: begin
        mac_req.acc_en   = 1'b1;
        mac_req.acc_load = (k_r == 3'd0);
        if (k_r == dst_last) begin
          state_nxt = ST_B_ERR;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = ST_B_RD;
        end
      end
      ST_B_ERR: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(act_rd);
        mac_req.b      = 17'sd4096 - 17'(act_rd);
        state_nxt      = ST_B_DR;
      end
      ST_B_DR: state_nxt = ST_B_M;
      ST_B_M: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(err_r);
        mac_req.b      = {6'b0, d_r};
        state_nxt      = ST_B_W;
      end
      ST_B_W: begin
        k_nxt     = '0;
        state_nxt = ST_B_RD;
        if (j_r == src_last) begin
          j_nxt = '0;
          if (l_r == 2'd1) begin
            l_nxt     = '0;
            state_nxt = ST_U_RD;
          end else begin
            l_nxt = l_r - 2'd1;
          end
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      // weight update: lr*delta, then *activation, then write back
      ST_U_RD: begin
        mem_req.re     = 1'b1;
        mem_req.addr   = {l_r, k_r, j_r};
        mac_req.mul_en = 1'b1;
        mac_req.a      = 31'(dlt_rd);
        mac_req.b      = {4'b0, lr};
        state_nxt      = ST_U_M2;
      end
      ST_U_M2: begin
        mac_req.mul_en = 1'b1;
        mac_req.a      = mac_out.prod[30:0];
        mac_req.b      = 17'(act_rd);
        state_nxt      = ST_U_WR;
      end
      ST_U_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = {l_r, k_r, j_r};
        mem_req.wdata = mlp_pkg::sat16(48'(mem_rdata) - mlp_pkg::round24(mac_out.prod));
        state_nxt     = ST_U_RD;
        if (k_r == src_last) begin
          k_nxt = '0;
          if (j_r == dst_last) begin
            j_nxt = '0;
            if (l_r == 2'(HIDDEN_LAYERS)) begin
              state_nxt = ST_DONE;
            end else begin
              l_nxt = l_r + 2'd1;
            end
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      l_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      l_r     <= l_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Datapath registers and neuron stores
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r     <= in_item.op;
          cls_r    <= in_item.target_class;
          act_r[0] <= in_item.x;
          act_r[1] <= in_item.y;
          res_r    <= '0;
        end
      end
      ST_RDW:   res_r.weight_read <= mem_rdata;
      ST_F_SIG: sig_r <= sig_tbl[sig_idx];
      ST_F_WR:  act_r[db + AW'(j_r)] <= {3'b000, sig_r};
      ST_RES: begin
        res_r.out_red     <= act_r[AW'(OB)][12:0];
        res_r.out_green   <= act_r[AW'(OB1)][12:0];
        res_r.out_blue    <= (OUTPUT_COUNT == 2) ? 13'd0 : act_r[AW'(OB2)][12:0];
        res_r.weight_read <= '0;
      end
      ST_O_DR, ST_B_DR: d_r <= 11'(mlp_pkg::round12(mac_out.prod));
      ST_O_W:   dlt_r[AW'(OB) + AW'(j_r)] <= mlp_pkg::sat16(mlp_pkg::round12(mac_out.prod));
      ST_B_ERR: err_r <= z;
      ST_B_W:   dlt_r[sb + AW'(j_r)] <= mlp_pkg::sat16(mlp_pkg::round12(mac_out.prod));
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mlp_sigmoid_train_infer_top.sv
// Two-input perceptron (HIDDEN_LAYERS hidden layers of HIDDEN_WIDTH sigmoid
// neurons, OUTPUT_COUNT sigmoid outputs, Q4.12) with a 256-entry weight store.
// Ops: write weight, read weight, infer, train (forward pass then one
// backpropagation step). One request is processed at a time; in_ch.ready is
// low while it runs. Every multiply goes through one shared 31x17 multiplier,
// and each weight visit reads the single-port weight store, multiplies, then
// accumulates or writes back. After reset the weight store is zeroed before
// the first request is taken; learning rate writes are accepted at any time
// but belong between requests.
`default_nettype none
`include "mlp_sigmoid_train_infer_top_defines.svh"

module mlp_sigmoid_train_infer_top #(
  parameter int HIDDEN_LAYERS       = 2,
  parameter int HIDDEN_WIDTH        = 8,
  parameter int OUTPUT_COUNT        = 3,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mlp_in_if.sink    in_ch,
  mlp_out_if.source out_ch,
  mlp_cfg_if.sink   cfg_ch
);

  logic [12:0]        lr_r;
  logic               out_vld_r;
  mlp_pkg::res_t      out_r;
  mlp_pkg::item_t     item;
  mlp_pkg::res_t      res;
  logic               res_valid;
  logic               res_ready;
  logic               in_ready;
  mlp_pkg::mem_req_t  mem_req;
  logic signed [15:0] mem_rdata;
  mlp_pkg::mac_req_t  mac_req;
  mlp_pkg::mac_out_t  mac_out;

  assign item.op           = in_ch.op;
  assign item.x            = in_ch.x;
  assign item.y            = in_ch.y;
  assign item.target_class = in_ch.target_class;
  assign item.weight_index = in_ch.weight_index;
  assign item.weight_value = in_ch.weight_value;
  assign in_ch.ready       = in_ready;

  // Learning rate register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= mlp_pkg::LR_RESET;
    end else if (cfg_ch.valid) begin
      lr_r <= cfg_ch.step_size;
    end
  end

  mlp_wmem u_wmem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mlp_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_out)
  );

  mlp_ctrl #(
    .HIDDEN_LAYERS       (HIDDEN_LAYERS),
    .HIDDEN_WIDTH        (HIDDEN_WIDTH),
    .OUTPUT_COUNT        (OUTPUT_COUNT),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_item   (item),
    .lr        (lr_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .mac_req   (mac_req),
    .mac_out   (mac_out)
  );

  // Output register
  assign res_ready = !out_vld_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_ready) begin
      out_vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_red     = out_r.out_red;
  assign out_ch.out_green   = out_r.out_green;
  assign out_ch.out_blue    = out_r.out_blue;
  assign out_ch.weight_read = out_r.weight_read;

  // Checks
  `MLP_ASSERT_NXT(a_busy_after_req, in_ch.valid && in_ready, !in_ready)
  `MLP_ASSERT_NXT(a_result_loaded, res_valid && res_ready, out_vld_r)
  `MLP_ASSERT_IMP(a_read_only_weight, out_vld_r && out_r.weight_read != 16'sd0,
                  out_r.out_red == 13'd0 && out_r.out_green == 13'd0 && out_r.out_blue == 13'd0)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_HID    = 2;
  localparam int W_HID    = 8;
  localparam int N_OUT    = 3;
  localparam int TAB_D    = 256;
  localparam int N_NEUR   = 2 + N_HID * W_HID + N_OUT;
  localparam int IDLE_MAX = 20000;
  localparam int N_ITEMS  = 1500;

  logic clk;
  logic rst_n;

  mlp_in_if  in_ch ();
  mlp_out_if out_ch ();
  mlp_cfg_if cfg_ch ();

  mlp_sigmoid_train_infer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // network shadow state
  int            wts [256];
  int            act [N_NEUR];
  int            dlt [N_NEUR];
  int            sig_tab [TAB_D];
  logic [12:0]   lr_shadow;
  mlp_pkg::res_t pending_res [$];
  int            fail_cnt;
  int            sent_cnt;
  int            idle_cycles;
  bit            in_calm;
  bit            out_calm;
  int            out_stall;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------- prediction ----------------
  function automatic longint rsh(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // 1/(1+e^mag) in Q0.12, exp from a truncated series then squared four times
  function automatic int sig_neg(longint unsigned mag);
    longint unsigned u, term, s, d;
    u = mag << 8;
    term = 64'd1 << 24;
    s = term;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * u) >> 24) / n;
      s += term;
    end
    for (int n = 0; n < 4; n++) s = (s * s) >> 24;
    d = (64'd1 << 24) + s;
    return int'(((64'd1 << 36) + d / 2) / d);
  endfunction

  function automatic int layer_base(int l);
    return (l == 0) ? 0 : 2 + (l - 1) * W_HID;
  endfunction

  function automatic int layer_size(int l);
    if (l == 0) return 2;
    if (l == N_HID + 1) return N_OUT;
    return W_HID;
  endfunction

  function automatic int slope(int a);
    return int'(rsh(longint'(a) * (4096 - a), 12));
  endfunction

  function automatic void run_forward(int xv, int yv);
    longint acc;
    int z;
    act[0] = xv;
    act[1] = yv;
    for (int l = 0; l <= N_HID; l++) begin
      for (int j = 0; j < layer_size(l + 1); j++) begin
        acc = 0;
        for (int k = 0; k < layer_size(l); k++)
          acc += longint'(wts[(l * 64 + k * 8 + j) & 255]) * act[layer_base(l) + k];
        z = clamp16(rsh(acc, 12));
        act[layer_base(l + 1) + j] = sig_tab[((z + 32768) * TAB_D) >> 16];
      end
    end
  endfunction

  function automatic void run_backprop(int cls);
    int ob, a, tgt, err, wi;
    longint acc;
    ob = layer_base(N_HID + 1);
    for (int j = 0; j < N_OUT; j++) begin
      a = act[ob + j];
      tgt = 0;
      if (cls < mlp_pkg::ONEHOT_CLASSES) tgt = mlp_pkg::ONE_HOT[cls][j] ? 4096 : 0;
      else if (cls == mlp_pkg::CLS_WHITE) tgt = 4096;
      dlt[ob + j] = clamp16(rsh(longint'(a - tgt) * slope(a), 12));
    end
    for (int l = N_HID; l >= 1; l--) begin
      for (int j = 0; j < layer_size(l); j++) begin
        acc = 0;
        for (int k = 0; k < layer_size(l + 1); k++)
          acc += longint'(dlt[layer_base(l + 1) + k]) * wts[(l * 64 + j * 8 + k) & 255];
        err = clamp16(rsh(acc, 12));
        dlt[layer_base(l) + j] =
          clamp16(rsh(longint'(err) * slope(act[layer_base(l) + j]), 12));
      end
    end
    // weights change only after every delta is known
    for (int l = 0; l <= N_HID; l++)
      for (int j = 0; j < layer_size(l + 1); j++)
        for (int k = 0; k < layer_size(l); k++) begin
          wi = (l * 64 + k * 8 + j) & 255;
          wts[wi] = clamp16(longint'(wts[wi]) - rsh(longint'(lr_shadow) *
                    dlt[layer_base(l + 1) + j] * act[layer_base(l) + k], 24));
        end
  endfunction

  function automatic mlp_pkg::res_t predict_result(mlp_pkg::item_t it);
    mlp_pkg::res_t r;
    int ob;
    r = '0;
    ob = layer_base(N_HID + 1);
    case (it.op)
      mlp_pkg::OP_WRITE: wts[it.weight_index] = int'(it.weight_value);
      mlp_pkg::OP_READ:  r.weight_read = 16'(wts[it.weight_index]);
      default: begin
        run_forward(int'(it.x), int'(it.y));
        r.out_red   = 13'(act[ob]);
        r.out_green = 13'(act[ob + 1]);
        r.out_blue  = 13'(act[ob + 2]);
        if (it.op == mlp_pkg::OP_TRAIN) run_backprop(int'(it.target_class));
      end
    endcase
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready = 1'b0;
      out_stall--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    mlp_pkg::res_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result red=%0d green=%0d blue=%0d wread=%0d", $time,
                 out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.weight_read);
        fail_cnt++;
      end else begin
        want = pending_res.pop_front();
        if (out_ch.out_red !== want.out_red) begin
          $display("%0t: out_red exp %0d got %0d", $time, want.out_red, out_ch.out_red);
          fail_cnt++;
        end
        if (out_ch.out_green !== want.out_green) begin
          $display("%0t: out_green exp %0d got %0d", $time, want.out_green,
                   out_ch.out_green);
          fail_cnt++;
        end
        if (out_ch.out_blue !== want.out_blue) begin
          $display("%0t: out_blue exp %0d got %0d", $time, want.out_blue, out_ch.out_blue);
          fail_cnt++;
        end
        if (out_ch.weight_read !== want.weight_read) begin
          $display("%0t: weight_read exp %0d got %0d", $time, want.weight_read,
                   out_ch.weight_read);
          fail_cnt++;
        end
      end
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      out_stall = out_calm ? 0 : $urandom_range(0, 19);
    end
  end

  // watchdog on cycles where no handshake completes
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_MAX);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // ---------------- request side ----------------
  task automatic send_request(mlp_pkg::item_t it);
    int gap;
    mlp_pkg::res_t exp_res;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    in_ch.op           = it.op;
    in_ch.x            = it.x;
    in_ch.y            = it.y;
    in_ch.target_class = it.target_class;
    in_ch.weight_index = it.weight_index;
    in_ch.weight_value = it.weight_value;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    exp_res = predict_result(it);
    pending_res.insert(pending_res.size(), exp_res);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(logic [12:0] rate);
    wait_drained();
    @(negedge clk);
    cfg_ch.step_size = rate;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    lr_shadow = rate;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic mlp_pkg::item_t mk(logic [1:0] op, int xv, int yv, int cls, int idx,
                                        int wv);
    mlp_pkg::item_t it;
    it.op           = op;
    it.x            = 16'(xv);
    it.y            = 16'(yv);
    it.target_class = 3'(cls);
    it.weight_index = 8'(idx);
    it.weight_value = 16'(wv);
    return it;
  endfunction

  // mostly moderate weights so the sigmoids do not all saturate
  function automatic int rnd_weight();
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom()));
    return $urandom_range(0, 16383) - 8192;
  endfunction

  function automatic int rnd_input();
    if ($urandom_range(0, 4) == 0) return $signed(16'($urandom()));
    return $urandom_range(0, 32767) - 16384;
  endfunction

  function automatic int rnd_net_index();
    int l, k, j;
    l = $urandom_range(0, 2);
    k = $urandom_range(0, (l == 0) ? 1 : 7);
    j = $urandom_range(0, (l == 2) ? 2 : 7);
    return l * 64 + k * 8 + j;
  endfunction

  // ---------------- tests ----------------
  task automatic test_cleared_store();
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 255, 0));
    send_request(mk(mlp_pkg::OP_INFER, 32767, -32768, 0, 0, 0));
  endtask

  task automatic test_weight_access();
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 0, -32768));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 255, 32767));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 200, 16'h5A5A));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 255, 0));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 200, 0));
    send_request(mk(mlp_pkg::OP_WRITE, -1, -1, 7, 0, 0));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 255, 0));
  endtask

  task automatic test_forward_extremes();
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 0, 4096));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 9, -4096));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 64, 8192));
    send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, 128, -6000));
    send_request(mk(mlp_pkg::OP_INFER, 32767, 32767, 0, 0, 0));
    send_request(mk(mlp_pkg::OP_INFER, -32768, -32768, 0, 0, 0));
    send_request(mk(mlp_pkg::OP_INFER, 0, 0, 0, 0, 0));
  endtask

  task automatic test_train_classes();
    for (int c = 0; c < 8; c++)
      send_request(mk(mlp_pkg::OP_TRAIN, 2048 * c - 8000, 3000, c, 0, 0));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 0, 0));
  endtask

  task automatic test_rate_extremes();
    write_rate(13'd0);
    send_request(mk(mlp_pkg::OP_TRAIN, 4096, -4096, 0, 0, 0));
    write_rate(13'd4096);
    send_request(mk(mlp_pkg::OP_TRAIN, 4096, -4096, 3, 0, 0));
    write_rate(13'h1FFF);
    send_request(mk(mlp_pkg::OP_TRAIN, -4096, 4096, 4, 0, 0));
    send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, 64, 0));
    write_rate(mlp_pkg::LR_RESET);
  endtask

  task automatic test_random_sessions();
    int since_rate;
    since_rate = 0;
    while (sent_cnt < N_ITEMS) begin
      // load part of the network, then exercise it
      repeat ($urandom_range(4, 24))
        send_request(mk(mlp_pkg::OP_WRITE, 0, 0, 0, rnd_net_index(), rnd_weight()));
      repeat ($urandom_range(2, 10)) begin
        case ($urandom_range(0, 19))
          0, 1: send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, $urandom_range(0, 255), 0));
          2, 3: send_request(mk(mlp_pkg::OP_READ, 0, 0, 0, rnd_net_index(), 0));
          4: send_request(mk(2'($urandom_range(0, 3)), int'($urandom()), int'($urandom()),
                             $urandom_range(0, 7), $urandom_range(0, 255),
                             int'($urandom())));
          5, 6, 7, 8, 9, 10:
            send_request(mk(mlp_pkg::OP_INFER, rnd_input(), rnd_input(),
                            $urandom_range(0, 7), 0, 0));
          default:
            send_request(mk(mlp_pkg::OP_TRAIN, rnd_input(), rnd_input(),
                            $urandom_range(0, 7), 0, 0));
        endcase
      end
      since_rate++;
      if (since_rate >= 20) begin
        since_rate = 0;
        case ($urandom_range(0, 3))
          0: write_rate(13'd0);
          1: write_rate(13'h1FFF);
          default: write_rate(13'($urandom_range(0, 4096)));
        endcase
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TAB_D; i++) begin
      int t;
      t = -32768 + (i * 65536) / TAB_D;
      sig_tab[i] = (t < 0) ? sig_neg(longint'(-t)) : 4096 - sig_neg(longint'(t));
    end
    for (int i = 0; i < 256; i++) wts[i] = 0;
    lr_shadow = mlp_pkg::LR_RESET;
    fail_cnt = 0;
    sent_cnt = 0;
    idle_cycles = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    out_stall = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = mlp_pkg::OP_WRITE;
    in_ch.x = '0;
    in_ch.y = '0;
    in_ch.target_class = '0;
    in_ch.weight_index = '0;
    in_ch.weight_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.step_size = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_cleared_store();
    test_weight_access();
    test_forward_extremes();
    wait_drained();
    test_train_classes();
    test_rate_extremes();
    test_random_sessions();

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
